[sv/lbvs_pkg.sv]
package lbvs_pkg;

   typedef struct packed {
      logic               req_type;
      logic               attr_mode;
      logic signed [31:0] vec_x;
      logic signed [31:0] vec_y;
      logic signed [31:0] vec_z;
      logic [7:0]         bone_a;
      logic [7:0]         bone_b;
      logic [7:0]         bone_c;
      logic [7:0]         bone_d;
      logic [16:0]        weight_a;
      logic [16:0]        weight_b;
      logic [16:0]        weight_c;
   } req_item_type;

   typedef struct packed {
      logic signed [31:0] out_x;
      logic signed [31:0] out_y;
      logic signed [31:0] out_z;
      logic               saturated;
      logic               bad_slot;
   } rsp_item_type;

   localparam logic REQ_LOAD    = 1'b0;
   localparam logic REQ_SKIN    = 1'b1;
   localparam logic MODE_ROTATE = 1'b0;
   localparam logic MODE_FULL   = 1'b1;

   localparam int MAX_LANES   = 4;
   localparam int MAT_ROWS    = 4;
   localparam int WEIGHT_BITS = 19;
   localparam int WPROD_BITS  = 51;
   localparam int SQRT_STEPS  = 32;
   localparam int DIV_STEPS   = 17;

   typedef struct packed {
      logic                 mode;
      logic                 rigid;
      logic                 bad;
      logic [MAX_LANES-1:0] lane_use;
   } ctl_type;

   typedef struct packed {
      logic [MAT_ROWS-1:0] row_en;
      logic [7:0]          slot;
      logic [95:0]         data;
   } pal_wr_type;

   typedef struct packed {
      logic               sat;
      logic signed [31:0] val;
   } clamp_type;

   function automatic logic signed [48:0] round_q16(input logic signed [63:0] p);
      logic signed [64:0] t;
      t = 65'(p) + 65'sd32768;
      return $signed(t[64:16]);
   endfunction

   function automatic clamp_type sat32(input logic signed [52:0] v);
      clamp_type c;
      c.sat = 1'b0;
      c.val = v[31:0];
      if (v > 53'sd2147483647) begin
         c.sat = 1'b1;
         c.val = 32'sh7FFFFFFF;
      end else if (v < -53'sd2147483648) begin
         c.sat = 1'b1;
         c.val = 32'sh80000000;
      end
      return c;
   endfunction

endpackage

[sv/lbvs_ram.sv]
module lbvs_ram #(
   parameter int WIDTH = 96,
   parameter int DEPTH = 64,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic                 clock,
   input  logic                 wr_en,
   input  logic [AW-1:0]        wr_addr,
   input  logic [WIDTH-1:0]     wr_data,
   input  logic                 rd_en,
   input  logic [AW-1:0]        rd_addr,
   output logic [WIDTH-1:0]     rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

[sv/lbvs_lane.sv]
module lbvs_lane import lbvs_pkg::*; #(
   parameter int PALETTE_SIZE = 64
) (
   input  logic                          clock,
   input  logic                          en,
   input  pal_wr_type                    pal_wr,
   input  logic [7:0]                    rd_slot,
   input  logic signed [31:0]            vec [3],
   input  logic                          mode,
   input  logic signed [WEIGHT_BITS-1:0] weight,
   output logic signed [WPROD_BITS-1:0]  wprod [3],
   output logic signed [31:0]            t_out [3],
   output logic                          sat_out
);
   localparam int AW = (PALETTE_SIZE > 1) ? $clog2(PALETTE_SIZE) : 1;

   logic [95:0]                   row_q [MAT_ROWS];
   logic signed [63:0]            p_ff [3][3];
   logic signed [31:0]            tr_ff [3];
   logic signed [WEIGHT_BITS-1:0] w1_ff, w2_ff;
   logic signed [31:0]            t2_ff [3];
   logic                          sat2_ff;
   logic signed [52:0]            sum_in [3];
   clamp_type                     cl_in [3];

   for (genvar r = 0; r < MAT_ROWS; r++) begin : g_row
      lbvs_ram #(.WIDTH(96), .DEPTH(PALETTE_SIZE)) u_row (
         .clock   (clock),
         .wr_en   (pal_wr.row_en[r]),
         .wr_addr (pal_wr.slot[AW-1:0]),
         .wr_data (pal_wr.data),
         .rd_en   (en),
         .rd_addr (rd_slot[AW-1:0]),
         .rd_data (row_q[r])
      );
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int r = 0; r < 3; r++) begin
            for (int j = 0; j < 3; j++) begin
               p_ff[r][j] <= vec[r] * $signed(row_q[r][32*j +: 32]);
            end
         end
         for (int j = 0; j < 3; j++) begin
            tr_ff[j] <= (mode == MODE_FULL) ? $signed(row_q[3][32*j +: 32]) : 32'sd0;
         end
         w1_ff <= weight;
      end
   end

   always_comb begin
      for (int j = 0; j < 3; j++) begin
         sum_in[j] = 53'(round_q16(p_ff[0][j])) + 53'(round_q16(p_ff[1][j]))
                   + 53'(round_q16(p_ff[2][j])) + 53'(tr_ff[j]);
         cl_in[j]  = sat32(sum_in[j]);
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            t2_ff[j] <= cl_in[j].val;
         end
         sat2_ff <= cl_in[0].sat | cl_in[1].sat | cl_in[2].sat;
         w2_ff   <= w1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            wprod[j] <= w2_ff * t2_ff[j];
            t_out[j] <= t2_ff[j];
         end
         sat_out <= sat2_ff;
      end
   end

endmodule

[sv/lbvs_merge.sv]
module lbvs_merge import lbvs_pkg::*; #(
   parameter int LANES = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         en,
   input  logic                         valid_in,
   input  ctl_type                      ctl_in,
   input  logic signed [WPROD_BITS-1:0] wprod [LANES][3],
   input  logic signed [31:0]           t0 [3],
   input  logic [LANES-1:0]             lane_sat,
   output logic                         valid_out,
   output ctl_type                      ctl_out,
   output logic signed [31:0]           r_out [3],
   output logic                         sat_out
);
   logic signed [52:0] acc_in [3];
   logic signed [53:0] rnd_in [3];
   clamp_type          cl_in [3];
   logic               sat_in;

   always_comb begin
      sat_in = 1'b0;
      for (int i = 0; i < LANES; i++) begin
         sat_in = sat_in | (lane_sat[i] & ctl_in.lane_use[i]);
      end
      for (int j = 0; j < 3; j++) begin
         acc_in[j] = '0;
         for (int i = 0; i < LANES; i++) begin
            acc_in[j] = acc_in[j] + 53'(wprod[i][j]);
         end
         rnd_in[j] = 54'(acc_in[j]) + 54'sd32768;
         cl_in[j]  = sat32(53'($signed(rnd_in[j][53:16])));
         if (!ctl_in.rigid) begin
            sat_in = sat_in | cl_in[j].sat;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out <= 1'b0;
      end else if (en) begin
         valid_out <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ctl_out <= ctl_in;
         sat_out <= sat_in;
         for (int j = 0; j < 3; j++) begin
            r_out[j] <= ctl_in.rigid ? t0[j] : cl_in[j].val;
         end
      end
   end

endmodule

[sv/lbvs_norm.sv]
module lbvs_norm import lbvs_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               en,
   input  logic               valid_in,
   input  ctl_type            ctl_in,
   input  logic signed [31:0] r_in [3],
   input  logic               sat_in,
   output logic               valid_out,
   output rsp_item_type       data_out
);
   typedef struct packed {
      logic             mode;
      logic             rigid;
      logic             bad;
      logic             sat;
      logic             zero;
      logic [2:0]       neg;
      logic [2:0][31:0] a;
      logic [2:0][31:0] r;
   } carry_type;

   logic             v1_ff;
   carry_type        c1_ff;
   logic [63:0]      sq1_ff [3];
   carry_type        c1_in;
   carry_type        sc0_in;

   logic             sv_ff [SQRT_STEPS+1];
   carry_type        sc_ff [SQRT_STEPS+1];
   logic [63:0]      sn_ff [SQRT_STEPS+1];
   logic [63:0]      sr_ff [SQRT_STEPS+1];
   logic [63:0]      len2_in;

   logic             dv_ff [DIV_STEPS+1];
   carry_type        dc_ff [DIV_STEPS+1];
   logic [2:0][48:0] drem_ff [DIV_STEPS+1];
   logic [2:0][16:0] dq_ff [DIV_STEPS+1];
   logic [31:0]      dden_ff [DIV_STEPS+1];
   logic [31:0]      len_in;

   rsp_item_type     out_in;

   always_comb begin
      c1_in       = '0;
      c1_in.mode  = ctl_in.mode;
      c1_in.rigid = ctl_in.rigid;
      c1_in.bad   = ctl_in.bad;
      c1_in.sat   = sat_in;
      for (int j = 0; j < 3; j++) begin
         c1_in.neg[j] = r_in[j][31];
         c1_in.a[j]   = r_in[j][31] ? 32'(-r_in[j]) : r_in[j];
         c1_in.r[j]   = r_in[j];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff    <= 1'b0;
         sv_ff[0] <= 1'b0;
      end else if (en) begin
         v1_ff    <= valid_in;
         sv_ff[0] <= v1_ff;
      end
   end

   assign len2_in = sq1_ff[0] + sq1_ff[1] + sq1_ff[2];

   always_comb begin
      sc0_in      = c1_ff;
      sc0_in.zero = (len2_in == 64'd0);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         c1_ff <= c1_in;
         for (int j = 0; j < 3; j++) begin
            sq1_ff[j] <= 64'(c1_in.a[j]) * 64'(c1_in.a[j]);
         end
         sc_ff[0] <= sc0_in;
         sn_ff[0] <= len2_in;
         sr_ff[0] <= 64'd0;
      end
   end

   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [64:0] trial;
      logic [63:0] n_in, res_in;

      always_comb begin
         trial = {1'b0, sr_ff[k]} + {1'b0, BIT};
         if ({1'b0, sn_ff[k]} >= trial) begin
            n_in   = sn_ff[k] - trial[63:0];
            res_in = (sr_ff[k] >> 1) + BIT;
         end else begin
            n_in   = sn_ff[k];
            res_in = sr_ff[k] >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            sv_ff[k+1] <= 1'b0;
         end else if (en) begin
            sv_ff[k+1] <= sv_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            sc_ff[k+1] <= sc_ff[k];
            sn_ff[k+1] <= n_in;
            sr_ff[k+1] <= res_in;
         end
      end
   end

   assign len_in = sr_ff[SQRT_STEPS][31:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= sv_ff[SQRT_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         dc_ff[0]   <= sc_ff[SQRT_STEPS];
         dden_ff[0] <= len_in;
         dq_ff[0]   <= '0;
         for (int j = 0; j < 3; j++) begin
            drem_ff[0][j] <= 49'({sc_ff[SQRT_STEPS].a[j], 16'h0000}) + 49'(len_in >> 1);
         end
      end
   end

   for (genvar i = 0; i < DIV_STEPS; i++) begin : g_div
      localparam int K = DIV_STEPS - 1 - i;
      logic [48:0]      cmp;
      logic [2:0][48:0] rem_in;
      logic [2:0][16:0] q_in;

      always_comb begin
         cmp = 49'(dden_ff[i]) << K;
         for (int j = 0; j < 3; j++) begin
            rem_in[j] = drem_ff[i][j];
            q_in[j]   = dq_ff[i][j];
            if (drem_ff[i][j] >= cmp) begin
               rem_in[j]  = drem_ff[i][j] - cmp;
               q_in[j][K] = 1'b1;
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[i+1] <= 1'b0;
         end else if (en) begin
            dv_ff[i+1] <= dv_ff[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            dc_ff[i+1]   <= dc_ff[i];
            dden_ff[i+1] <= dden_ff[i];
            drem_ff[i+1] <= rem_in;
            dq_ff[i+1]   <= q_in;
         end
      end
   end

   always_comb begin
      carry_type        c;
      logic [2:0][31:0] res;
      c = dc_ff[DIV_STEPS];
      for (int j = 0; j < 3; j++) begin
         res[j] = c.r[j];
         if (!c.rigid && c.mode == MODE_ROTATE && !c.zero) begin
            res[j] = c.neg[j] ? 32'(-{15'd0, dq_ff[DIV_STEPS][j]})
                              : {15'd0, dq_ff[DIV_STEPS][j]};
         end
      end
      out_in.out_x     = res[0];
      out_in.out_y     = res[1];
      out_in.out_z     = res[2];
      out_in.saturated = c.sat;
      out_in.bad_slot  = c.bad;
      if (c.bad) begin
         out_in.out_x     = '0;
         out_in.out_y     = '0;
         out_in.out_z     = '0;
         out_in.saturated = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_out <= 1'b0;
      end else if (en) begin
         valid_out <= dv_ff[DIV_STEPS];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         data_out <= out_in;
      end
   end

endmodule

[sv/linear_blend_vertex_skinning_top.sv]
// Linear blend vertex skinning against a palette of 4x3 bone matrices.
// The request channel carries load items, which write one matrix row and give no
// response, and vertex items, which give one response each. The csr port sets the
// number of bone influences; the user must write it only while the block is idle,
// which the block does not enforce. One item is taken every cycle while req_stall
// is low. One lane per influence reads its bone matrix from four row memories and
// transforms the vector; a merge stage blends the lanes by weight, and a normalize
// stage with a 32-step square root pipeline and a 17-step divider pipeline finishes
// rotated vectors. Throughput is one item per cycle while the response side does
// not stall, set by the pipelined multipliers, square root and divider stages.
// Reset clears all valid state and sets the influence count to zero (rigid mode).
// Palette contents are undefined until loaded.
// When the receiver stalls, the response register holds its item and a skid
// register takes one more; req_stall rises only once the skid register is full.
module linear_blend_vertex_skinning_top import lbvs_pkg::*; #(
   parameter int PALETTE_SIZE   = 64,
   parameter int MAX_INFLUENCES = 4
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_stall,
   input  req_item_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_stall,
   output rsp_item_type rsp_data,
   input  logic         csr_wr_en,
   input  logic [2:0]   csr_wr_data
);
   localparam int          LANES = MAX_INFLUENCES;
   localparam logic [8:0]  PS9   = 9'(PALETTE_SIZE);

   logic       en;
   logic       accept;
   logic [2:0] weights_in_use_ff;

   logic [2:0]                    n_in;
   logic [7:0]                    slot_in [4];
   logic [16:0]                   w_in [4];
   logic signed [WEIGHT_BITS-1:0] last_in;
   logic signed [WEIGHT_BITS-1:0] lw_in [LANES];
   logic [7:0]                    rd_slot_in [LANES];
   ctl_type                       ctl_in;
   pal_wr_type                    pal_wr_in;

   logic                          s0_valid_ff;
   ctl_type                       s0_ctl_ff;
   logic signed [31:0]            s0_vec_ff [3];
   logic signed [WEIGHT_BITS-1:0] s0_w_ff [LANES];

   logic    lv_ff [3];
   ctl_type lc_ff [3];

   logic signed [WPROD_BITS-1:0] l_wprod [LANES][3];
   logic signed [31:0]           l_t [LANES][3];
   logic [LANES-1:0]             l_sat;

   logic               m_valid;
   ctl_type            m_ctl;
   logic signed [31:0] m_r [3];
   logic               m_sat;

   logic         p_valid;
   rsp_item_type p_data;
   logic         rsp_valid_ff, skid_full_ff;
   rsp_item_type rsp_data_ff, skid_ff;

   assign en        = !skid_full_ff;
   assign req_stall = skid_full_ff;
   assign accept    = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         weights_in_use_ff <= 3'd0;
      end else if (csr_wr_en) begin
         weights_in_use_ff <= csr_wr_data;
      end
   end

   always_comb begin
      n_in = (weights_in_use_ff > 3'(MAX_INFLUENCES)) ? 3'(MAX_INFLUENCES)
                                                      : weights_in_use_ff;
      slot_in = '{req_data.bone_a, req_data.bone_b, req_data.bone_c, req_data.bone_d};
      w_in    = '{req_data.weight_a, req_data.weight_b, req_data.weight_c, 17'd0};
      last_in = 19'sd65536;
      for (int i = 0; i < 3; i++) begin
         if (3'(i + 1) < n_in) begin
            last_in = last_in - $signed({2'b00, w_in[i]});
         end
      end
      ctl_in          = '0;
      ctl_in.mode     = req_data.attr_mode;
      ctl_in.rigid    = (n_in == 3'd0);
      for (int i = 0; i < LANES; i++) begin
         ctl_in.lane_use[i] = ctl_in.rigid ? (i == 0) : (3'(i) < n_in);
         if (!ctl_in.rigid && 3'(i) < n_in && {1'b0, slot_in[i]} >= PS9) begin
            ctl_in.bad = 1'b1;
         end
         if (ctl_in.rigid) begin
            lw_in[i] = '0;
         end else if (3'(i + 1) < n_in) begin
            lw_in[i] = $signed({2'b00, w_in[i]});
         end else if (3'(i + 1) == n_in) begin
            lw_in[i] = last_in;
         end else begin
            lw_in[i] = '0;
         end
         rd_slot_in[i] = (ctl_in.rigid && i == 0) ? 8'd0 : slot_in[i];
      end
      pal_wr_in.slot = req_data.bone_a;
      pal_wr_in.data = {req_data.vec_z, req_data.vec_y, req_data.vec_x};
      for (int r = 0; r < MAT_ROWS; r++) begin
         pal_wr_in.row_en[r] = accept && req_data.req_type == REQ_LOAD
                            && {1'b0, req_data.bone_a} < PS9
                            && req_data.bone_b == 8'(r);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_valid_ff <= 1'b0;
         lv_ff       <= '{1'b0, 1'b0, 1'b0};
      end else if (en) begin
         s0_valid_ff <= accept && req_data.req_type == REQ_SKIN;
         lv_ff[0]    <= s0_valid_ff;
         lv_ff[1]    <= lv_ff[0];
         lv_ff[2]    <= lv_ff[1];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ctl_ff    <= ctl_in;
         s0_vec_ff[0] <= req_data.vec_x;
         s0_vec_ff[1] <= req_data.vec_y;
         s0_vec_ff[2] <= req_data.vec_z;
         s0_w_ff      <= lw_in;
         lc_ff[0]     <= s0_ctl_ff;
         lc_ff[1]     <= lc_ff[0];
         lc_ff[2]     <= lc_ff[1];
      end
   end

   for (genvar i = 0; i < LANES; i++) begin : g_lane
      lbvs_lane #(.PALETTE_SIZE(PALETTE_SIZE)) u_lane (
         .clock   (clock),
         .en      (en),
         .pal_wr  (pal_wr_in),
         .rd_slot (rd_slot_in[i]),
         .vec     (s0_vec_ff),
         .mode    (s0_ctl_ff.mode),
         .weight  (s0_w_ff[i]),
         .wprod   (l_wprod[i]),
         .t_out   (l_t[i]),
         .sat_out (l_sat[i])
      );
   end

   lbvs_merge #(.LANES(LANES)) u_merge (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (lv_ff[2]),
      .ctl_in    (lc_ff[2]),
      .wprod     (l_wprod),
      .t0        (l_t[0]),
      .lane_sat  (l_sat),
      .valid_out (m_valid),
      .ctl_out   (m_ctl),
      .r_out     (m_r),
      .sat_out   (m_sat)
   );

   lbvs_norm u_norm (
      .clock     (clock),
      .reset     (reset),
      .en        (en),
      .valid_in  (m_valid),
      .ctl_in    (m_ctl),
      .r_in      (m_r),
      .sat_in    (m_sat),
      .valid_out (p_valid),
      .data_out  (p_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         skid_full_ff <= 1'b0;
      end else begin
         if (!rsp_valid_ff || !rsp_stall) begin
            if (skid_full_ff) begin
               rsp_valid_ff <= 1'b1;
               rsp_data_ff  <= skid_ff;
               skid_full_ff <= 1'b0;
            end else begin
               rsp_valid_ff <= p_valid;
               rsp_data_ff  <= p_data;
            end
         end else if (p_valid && !skid_full_ff) begin
            skid_ff      <= p_data;
            skid_full_ff <= 1'b1;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[sv/lbvs_checker.sv]
module lbvs_checker import lbvs_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_item_type rsp_data
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed or dropped");

   a_bad_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.bad_slot |-> rsp_data.out_x == 0 && rsp_data.out_y == 0
         && rsp_data.out_z == 0 && !rsp_data.saturated)
      else $error("bad slot response is not zero");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      $rose(req_stall) |-> $past(rsp_valid && rsp_stall))
      else $error("request stall without a stalled response");

endmodule

bind linear_blend_vertex_skinning_top lbvs_checker u_lbvs_checker (.*);
